/* hdl/rbcd_pkg.sv */
package rbcd_pkg;

	localparam int MAX_PACKET_BYTES = 512;
	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

	localparam int BLOCK1_LEN = 12;
	localparam int BLOCK_LEN = 18;
	localparam int MIN_PACKET = 21;
	localparam int PAY_MAX = 16;
	localparam int CRC_BYTES = 2;
	localparam int FILL_W = $clog2(BLOCK_LEN + 1);
	localparam int CNT_W = $clog2(PAY_MAX + 1);
	localparam int PAY_IDX_W = $clog2(PAY_MAX);

	localparam int POS_SYNC0 = 1;
	localparam int POS_SYNC1 = 2;
	localparam int POS_INFO = 3;
	localparam int POS_ADDR_FIRST = 4;
	localparam int POS_ADDR_LAST = 9;
	localparam int POS_NPCI = 17;
	localparam logic [7:0] SYNC0 = 8'h44;
	localparam logic [7:0] SYNC1 = 8'hFF;

	localparam int NPCI_DOMAIN_BIT = 0;
	localparam int NPCI_FRAME_LSB = 1;
	localparam int NPCI_HOP_LSB = 4;
	localparam int NPCI_GROUP_BIT = 7;

	localparam int ADDR_W = 48;
	localparam int NPDU_W = 10;
	localparam int NPDU_BIAS = 7;

	localparam logic [15:0] CRC_POLY = 16'hA6BC;

	// Two payload buffers: one fills while the other drains.
	localparam int NBANKS = 2;
	localparam int BANK_W = $clog2(NBANKS);
	localparam int BUF_DEPTH = NBANKS * PAY_MAX;
	localparam int BUF_AW = $clog2(BUF_DEPTH);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	localparam int OF_DEPTH = 4;
	localparam int OF_AW = $clog2(OF_DEPTH);
	localparam int OF_CW = $clog2(OF_DEPTH + 1);
	localparam int OF_SW = OF_CW + 1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_SHORT = 3'd1,
		ST_BAD_HEADER = 3'd2,
		ST_CRC_ERROR = 3'd3,
		ST_DOMAIN_MISMATCH = 3'd4
	} status_t;

	typedef enum logic {
		ITEM_PAYLOAD = 1'b0,
		ITEM_STATUS = 1'b1
	} item_kind_t;

	typedef struct packed {
		status_t status;
		logic [7:0] rf_info;
		logic [ADDR_W-1:0] addr;
		logic [7:0] npci;
		logic [NPDU_W-1:0] npdu;
	} stat_t;

	typedef struct packed {
		logic has_blk;
		logic [BANK_W-1:0] bank;
		logic [CNT_W-1:0] count;
		logic has_stat;
		stat_t stat;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic [BANK_W-1:0] bank;
	} bank_rel_t;

	typedef struct packed {
		logic we;
		logic [BUF_AW-1:0] addr;
		logic [7:0] data;
	} buf_wr_t;

	typedef struct packed {
		logic re;
		logic [BUF_AW-1:0] addr;
	} buf_rd_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] payload;
		logic last;
		status_t status;
		logic [7:0] rf_info;
		logic [ADDR_W-1:0] addr;
		logic [2:0] frame;
		logic group;
		logic [2:0] hop;
		logic dbc;
		logic [NPDU_W-1:0] npdu;
	} res_item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hdl/rbcd_rx_if.sv */
interface rbcd_rx_if ();
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	logic end_of_packet;

	modport source(output valid, output rx_byte, output end_of_packet, input ready);
	modport sink(input valid, input rx_byte, input end_of_packet, output ready);
endinterface

/* hdl/rbcd_res_if.sv */
interface rbcd_res_if import rbcd_pkg::*; ();
	logic valid;
	logic ready;
	logic item_kind;
	logic [7:0] payload_byte;
	logic last_item;
	logic [2:0] status;
	logic [7:0] rf_info;
	logic [ADDR_W-1:0] serial_or_domain;
	logic [2:0] frame_number;
	logic group_address;
	logic [2:0] hop_count;
	logic domain_broadcast;
	logic [NPDU_W-1:0] npdu_length;

	modport source(output valid, output item_kind, output payload_byte, output last_item,
		output status, output rf_info, output serial_or_domain, output frame_number,
		output group_address, output hop_count, output domain_broadcast, output npdu_length,
		input ready);
	modport sink(input valid, input item_kind, input payload_byte, input last_item,
		input status, input rf_info, input serial_or_domain, input frame_number,
		input group_address, input hop_count, input domain_broadcast, input npdu_length,
		output ready);
endinterface

/* hdl/rf_block_crc_deframer_unit.sv */
// Block CRC deframer for received radio packets.
// The rx channel takes one packet byte per beat, with end_of_packet set on the
// last byte. The result channel gives the checked payload bytes of blocks two
// onward, CRC removed, and one status beat (last_item set) per packet.
// Payload may leave before the packet verdict; drop it unless status is ok.
// The user must write the domain register through cfg_wr_en/cfg_wr_data only
// while idle; the block itself leaves this unchecked. Throughput: one byte per
// cycle in, one result beat per cycle out, while neither side stalls. The
// front end checks each byte as it arrives and hands finished blocks to the
// back end through a four-entry command queue and a pair of 16-byte payload
// buffers. The first payload byte of a block, or the status beat, passes the
// queue, the command and stage-one registers and the output FIFO; payload then
// follows at one beat per cycle. When the receiver stalls, a four-beat output
// FIFO fills first, then the back end halts. The rx side keeps taking bytes
// until both payload buffers or the command queue are full. Reset clears all
// packet state and the domain register. The payload buffers are not cleared;
// no entry is read before it is written.
module rf_block_crc_deframer_unit import rbcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	rbcd_rx_if.sink rx,
	rbcd_res_if.source result,
	input logic cfg_wr_en,
	input logic [ADDR_W-1:0] cfg_wr_data
);

	logic [ADDR_W-1:0] domain_q;
	logic q_push, q_pop, q_valid, q_full;
	cmd_t push_cmd, head_cmd;
	bank_rel_t rel;
	buf_wr_t buf_wr;
	buf_rd_t buf_rd;
	logic [7:0] buf_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			domain_q <= '0;
		end else if (cfg_wr_en) begin
			domain_q <= cfg_wr_data;
		end
	end

	rbcd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.domain_address(domain_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(push_cmd),
		.rel(rel),
		.buf_wr(buf_wr)
	);

	rbcd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(push_cmd),
		.pop(q_pop),
		.valid(q_valid),
		.full(q_full),
		.head(head_cmd)
	);

	rbcd_buf u_buf (
		.clk(clk),
		.wr(buf_wr),
		.rd(buf_rd),
		.rdata(buf_rdata)
	);

	rbcd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_cmd(head_cmd),
		.q_pop(q_pop),
		.rel(rel),
		.buf_rd(buf_rd),
		.buf_rdata(buf_rdata),
		.res(result)
	);

endmodule

/* hdl/rbcd_buf.sv */
module rbcd_buf import rbcd_pkg::*; (
	input logic clk,
	input buf_wr_t wr,
	input buf_rd_t rd,
	output logic [7:0] rdata
);

	logic [7:0] mem_q [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			rdata <= mem_q[rd.addr];
		end
	end

endmodule

/* hdl/rbcd_queue.sv */
module rbcd_queue import rbcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	input logic pop,
	output logic valid,
	output logic full,
	output cmd_t head
);

	cmd_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] cnt_q;

	assign valid = (cnt_q != '0);
	assign full = (cnt_q == Q_CW'(Q_DEPTH));
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* hdl/rbcd_front.sv */
module rbcd_front import rbcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	rbcd_rx_if.sink rx,
	input logic [ADDR_W-1:0] domain_address,
	input logic q_full,
	output logic q_push,
	output cmd_t q_cmd,
	input bank_rel_t rel,
	output buf_wr_t buf_wr
);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [FILL_W-1:0] fill_q, fill_n, limit;
	logic [15:0] crc_q, crc_n;
	logic [7:0] prev1_q, prev1_n, prev2_q, prev2_n;
	logic hdr_q, hdr_n, blk_q, blk_n;
	logic [7:0] info_q, info_n, npci_q, npci_n;
	logic [ADDR_W-1:0] addr_q, addr_n;
	logic [NPDU_W-1:0] pcount_q, pcount_n;
	logic [BANK_W-1:0] cur_q;
	logic [NBANKS-1:0] busy_q;

	logic acc, in_range, first_blk, fin, first_fin, crc_ok, emit;
	logic [CNT_W-1:0] pay_cnt;
	status_t st;

	assign rx.ready = !busy_q[cur_q] && !q_full;
	assign acc = rx.valid && rx.ready;

	always_comb begin
		in_range = (pos_q < POS_W'(MAX_PACKET_BYTES));
		first_blk = (pos_q < POS_W'(BLOCK1_LEN));
		limit = first_blk ? FILL_W'(BLOCK1_LEN) : FILL_W'(BLOCK_LEN);
		pos_n = pos_q;
		fill_n = fill_q;
		crc_n = crc_q;
		prev1_n = prev1_q;
		prev2_n = prev2_q;
		hdr_n = hdr_q;
		blk_n = blk_q;
		info_n = info_q;
		addr_n = addr_q;
		npci_n = npci_q;

		if (in_range) begin
			// The CRC trails the incoming bytes by two, so the last two bytes
			// of a block never enter it.
			if (fill_q >= FILL_W'(CRC_BYTES)) begin
				crc_n = crc_byte(crc_q, prev2_q);
			end
			prev2_n = prev1_q;
			prev1_n = rx.rx_byte;
			fill_n = fill_q + FILL_W'(1);
			pos_n = pos_q + POS_W'(1);
			if ((pos_q == POS_W'(POS_SYNC0) && rx.rx_byte != SYNC0)
				|| (pos_q == POS_W'(POS_SYNC1) && rx.rx_byte != SYNC1)) begin
				hdr_n = 1'b0;
			end
			if (pos_q == POS_W'(POS_INFO)) begin
				info_n = rx.rx_byte;
			end
			if (pos_q >= POS_W'(POS_ADDR_FIRST) && pos_q <= POS_W'(POS_ADDR_LAST)) begin
				addr_n = {addr_q[ADDR_W-9:0], rx.rx_byte};
			end
			if (pos_q == POS_W'(POS_NPCI)) begin
				npci_n = rx.rx_byte;
			end
		end else begin
			blk_n = 1'b0;
		end

		fin = (in_range && fill_n == limit) || (rx.end_of_packet && fill_n != '0);
		first_fin = (pos_n <= POS_W'(BLOCK1_LEN));
		crc_ok = (fill_n >= FILL_W'(CRC_BYTES)) && ((~crc_n) == {prev2_n, prev1_n});
		if (fin && !crc_ok) begin
			blk_n = 1'b0;
		end
		emit = fin && !first_fin && crc_ok && hdr_n && blk_n;
		pay_cnt = CNT_W'(fill_n - FILL_W'(CRC_BYTES));
		pcount_n = emit ? (pcount_q + NPDU_W'(pay_cnt)) : pcount_q;

		if (pos_n < POS_W'(MIN_PACKET)) begin
			st = ST_SHORT;
		end else if (!hdr_n) begin
			st = ST_BAD_HEADER;
		end else if (!blk_n) begin
			st = ST_CRC_ERROR;
		end else if (npci_n[NPCI_DOMAIN_BIT] && addr_n != domain_address) begin
			st = ST_DOMAIN_MISMATCH;
		end else begin
			st = ST_OK;
		end

		q_cmd.has_blk = emit;
		q_cmd.bank = cur_q;
		q_cmd.count = pay_cnt;
		q_cmd.has_stat = rx.end_of_packet;
		q_cmd.stat.status = st;
		q_cmd.stat.rf_info = info_n;
		q_cmd.stat.addr = addr_n;
		q_cmd.stat.npci = npci_n;
		q_cmd.stat.npdu = (st == ST_OK) ? (pcount_n - NPDU_W'(NPDU_BIAS)) : '0;
	end

	assign q_push = acc && (emit || rx.end_of_packet);

	assign buf_wr.we = acc && in_range && (fill_q < FILL_W'(PAY_MAX));
	assign buf_wr.addr = {cur_q, fill_q[PAY_IDX_W-1:0]};
	assign buf_wr.data = rx.rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fill_q <= '0;
			crc_q <= '0;
			hdr_q <= 1'b1;
			blk_q <= 1'b1;
			info_q <= '0;
			addr_q <= '0;
			npci_q <= '0;
			pcount_q <= '0;
			cur_q <= '0;
			busy_q <= '0;
		end else begin
			if (acc) begin
				if (rx.end_of_packet) begin
					pos_q <= '0;
					fill_q <= '0;
					crc_q <= '0;
					hdr_q <= 1'b1;
					blk_q <= 1'b1;
					info_q <= '0;
					addr_q <= '0;
					npci_q <= '0;
					pcount_q <= '0;
				end else begin
					pos_q <= pos_n;
					fill_q <= fin ? '0 : fill_n;
					crc_q <= fin ? '0 : crc_n;
					hdr_q <= hdr_n;
					blk_q <= blk_n;
					info_q <= info_n;
					addr_q <= addr_n;
					npci_q <= npci_n;
					pcount_q <= pcount_n;
				end
				// A checked block hands its buffer to the back end.
				if (emit) begin
					busy_q[cur_q] <= 1'b1;
					cur_q <= cur_q + BANK_W'(1);
				end
			end
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			prev1_q <= prev1_n;
			prev2_q <= prev2_n;
		end
	end

endmodule

/* hdl/rbcd_back.sv */
module rbcd_back import rbcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input cmd_t q_cmd,
	output logic q_pop,
	output bank_rel_t rel,
	output buf_rd_t buf_rd,
	input logic [7:0] buf_rdata,
	rbcd_res_if.source res
);

	cmd_t cmd_q;
	logic cmd_v_q;
	logic [PAY_IDX_W-1:0] idx_q, idx_n;
	logic blk_done_q, blk_done_n;

	logic item_v_s1;
	item_kind_t kind_s1;
	stat_t stat_s1;

	res_item_t ofifo_q [OF_DEPTH];
	logic [OF_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OF_CW-1:0] ocnt_q;

	logic [OF_SW-1:0] occ;
	logic can_issue, issue, last_pay, cmd_done, opop;
	item_kind_t issue_kind;
	res_item_t item, head;

	// Items in the output FIFO plus the one in flight must leave room.
	assign occ = OF_SW'(ocnt_q) + OF_SW'(item_v_s1);
	assign can_issue = (occ < OF_SW'(OF_DEPTH));

	always_comb begin
		issue = 1'b0;
		issue_kind = ITEM_PAYLOAD;
		last_pay = 1'b0;
		cmd_done = 1'b0;
		idx_n = idx_q;
		blk_done_n = blk_done_q;
		rel.valid = 1'b0;
		rel.bank = cmd_q.bank;
		if (cmd_v_q) begin
			if (cmd_q.has_blk && !blk_done_q) begin
				if (cmd_q.count == '0) begin
					last_pay = 1'b1;
				end else if (can_issue) begin
					issue = 1'b1;
					if (CNT_W'(idx_q) + CNT_W'(1) == cmd_q.count) begin
						last_pay = 1'b1;
					end else begin
						idx_n = idx_q + PAY_IDX_W'(1);
					end
				end
				if (last_pay) begin
					rel.valid = 1'b1;
					idx_n = '0;
					blk_done_n = 1'b1;
					cmd_done = !cmd_q.has_stat;
				end
			end else if (cmd_q.has_stat) begin
				if (can_issue) begin
					issue = 1'b1;
					issue_kind = ITEM_STATUS;
					cmd_done = 1'b1;
				end
			end else begin
				cmd_done = 1'b1;
			end
		end
	end

	assign q_pop = q_valid && (!cmd_v_q || cmd_done);

	assign buf_rd.re = issue && (issue_kind == ITEM_PAYLOAD);
	assign buf_rd.addr = {cmd_q.bank, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_q <= 1'b0;
			idx_q <= '0;
			blk_done_q <= 1'b0;
			item_v_s1 <= 1'b0;
		end else begin
			if (q_pop) begin
				cmd_v_q <= 1'b1;
				idx_q <= '0;
				blk_done_q <= 1'b0;
			end else begin
				if (cmd_done) begin
					cmd_v_q <= 1'b0;
				end
				idx_q <= idx_n;
				blk_done_q <= blk_done_n;
			end
			item_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (issue) begin
			kind_s1 <= issue_kind;
			stat_s1 <= cmd_q.stat;
		end
	end

	// Buffer read data lines up with the stage-one registers.
	always_comb begin
		item = '0;
		item.kind = kind_s1;
		if (kind_s1 == ITEM_PAYLOAD) begin
			item.payload = buf_rdata;
		end else begin
			item.last = 1'b1;
			item.status = stat_s1.status;
			item.rf_info = stat_s1.rf_info;
			item.addr = stat_s1.addr;
			item.frame = stat_s1.npci[NPCI_FRAME_LSB +: 3];
			item.group = stat_s1.npci[NPCI_GROUP_BIT];
			item.hop = stat_s1.npci[NPCI_HOP_LSB +: 3];
			item.dbc = stat_s1.npci[NPCI_DOMAIN_BIT];
			item.npdu = stat_s1.npdu;
		end
	end

	assign head = ofifo_q[rd_ptr_q];
	assign res.valid = (ocnt_q != '0);
	assign opop = res.valid && res.ready;
	assign res.item_kind = head.kind;
	assign res.payload_byte = head.payload;
	assign res.last_item = head.last;
	assign res.status = head.status;
	assign res.rf_info = head.rf_info;
	assign res.serial_or_domain = head.addr;
	assign res.frame_number = head.frame;
	assign res.group_address = head.group;
	assign res.hop_count = head.hop;
	assign res.domain_broadcast = head.dbc;
	assign res.npdu_length = head.npdu;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (item_v_s1) begin
				wr_ptr_q <= wr_ptr_q + OF_AW'(1);
			end
			if (opop) begin
				rd_ptr_q <= rd_ptr_q + OF_AW'(1);
			end
			if (item_v_s1 && !opop) begin
				ocnt_q <= ocnt_q + OF_CW'(1);
			end else if (opop && !item_v_s1) begin
				ocnt_q <= ocnt_q - OF_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_v_s1) begin
			ofifo_q[wr_ptr_q] <= item;
		end
	end

endmodule

/* sim/rf_block_crc_deframer_unit_tb.sv */
module rf_block_crc_deframer_unit_tb;
	import rbcd_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 11;
	localparam int LIMIT_CYCLES = 400_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BYTES = 130;
	localparam int NO_VERDICT = -1;

	typedef enum int {
		DMG_NONE,
		DMG_SYNC0,
		DMG_SYNC1,
		DMG_HDR_CRC,
		DMG_BLK2,
		DMG_RANDOM,
		DMG_NOISE
	} damage_t;

	typedef struct packed {
		logic [7:0] data;
		logic eop;
	} rx_beat_t;

	typedef struct {
		int len;
		logic [7:0] info;
		logic [ADDR_W-1:0] addr;
		logic [7:0] npci;
		bit addr_is_domain;
		damage_t dmg;
		int verdict;
	} pkt_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [ADDR_W-1:0] cfg_wr_data;

	rbcd_rx_if rx_ch ();
	rbcd_res_if res_ch ();

	rf_block_crc_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.result(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Expected result beats, the status verdicts typed into the directed table,
	// the bytes waiting to be sent and the packet under construction.
	res_item_t deframed_q[$];
	int verdict_q[$];
	rx_beat_t byte_q[$];
	logic [7:0] pkt[$];
	pkt_row_t dir_rows[0:15];

	// Deframer state as the predictor sees it.
	logic [ADDR_W-1:0] dom_reg;
	logic [POS_W-1:0] rp_pos;
	logic [FILL_W-1:0] rp_fill;
	logic [7:0] rp_blk[BLOCK_LEN];
	logic [15:0] rp_crc;
	bit rp_hdr_ok;
	bit rp_blks_ok;
	logic [7:0] rp_info;
	logic [ADDR_W-1:0] rp_addr;
	logic [7:0] rp_npci;
	logic [NPDU_W-1:0] rp_pay;

	int err_cnt;
	int pkt_cnt;
	int bytes_queued;
	int bytes_in;
	int payload_out;
	int status_out;
	int st_seen[8];
	logic rx_taken;
	bit hold_req;
	bit hold_done;

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("rf_block_crc_deframer_unit_tb failed");
		$finish;
	end

	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		logic fb;
		r = c;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ d[k];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// Complemented CRC over cnt bytes of the packet under construction.
	function automatic logic [15:0] crc_span(input int from, input int cnt);
		logic [15:0] c;
		c = '0;
		for (int j = 0; j < cnt; j++) begin
			c = crc_next(c, pkt[from + j]);
		end
		return ~c;
	endfunction

	task automatic clear_packet();
		rp_pos = '0;
		rp_fill = '0;
		rp_crc = '0;
		rp_hdr_ok = 1'b1;
		rp_blks_ok = 1'b1;
		rp_info = '0;
		rp_addr = '0;
		rp_npci = '0;
		rp_pay = '0;
	endtask

	task automatic close_block(input int n, input bit is_first);
		bit good;
		res_item_t r;
		good = 1'b0;
		if (n >= 2 && n <= BLOCK_LEN) begin
			good = (~rp_crc) == {rp_blk[n - 2], rp_blk[n - 1]};
		end
		if (!good) begin
			rp_blks_ok = 1'b0;
		end
		if (!is_first && good && rp_hdr_ok && rp_blks_ok) begin
			for (int i = 0; i < n - 2; i++) begin
				r = '0;
				r.kind = ITEM_PAYLOAD;
				r.payload = rp_blk[i];
				deframed_q.push_back(r);
			end
			rp_pay = rp_pay + NPDU_W'(n - 2);
		end
		rp_fill = '0;
		rp_crc = '0;
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic eop);
		logic [POS_W-1:0] p;
		bit is_first;
		int lim;
		int v;
		status_t st;
		res_item_t r;
		p = rp_pos;
		if (p >= MAX_PACKET_BYTES) begin
			rp_blks_ok = 1'b0;
		end else begin
			is_first = p < BLOCK1_LEN;
			lim = is_first ? BLOCK1_LEN : BLOCK_LEN;
			if (rp_fill < BLOCK_LEN) begin
				rp_blk[rp_fill] = b;
				// The CRC trails the stored bytes by two, so it never covers the CRC field.
				if (rp_fill >= 2) begin
					rp_crc = crc_next(rp_crc, rp_blk[rp_fill - 2]);
				end
				rp_fill = rp_fill + 1'b1;
			end
			if ((p == POS_SYNC0 && b != SYNC0) || (p == POS_SYNC1 && b != SYNC1)) begin
				rp_hdr_ok = 1'b0;
			end
			if (p == POS_INFO) begin
				rp_info = b;
			end
			if (p >= POS_ADDR_FIRST && p <= POS_ADDR_LAST) begin
				rp_addr = {rp_addr[ADDR_W-9:0], b};
			end
			if (p == POS_NPCI) begin
				rp_npci = b;
			end
			if (rp_fill >= lim) begin
				close_block(rp_fill, is_first);
			end
			rp_pos = p + 1'b1;
		end
		if (eop) begin
			if (rp_fill > 0) begin
				close_block(rp_fill, rp_pos <= BLOCK1_LEN);
			end
			if (rp_pos < MIN_PACKET) begin
				st = ST_SHORT;
			end else if (!rp_hdr_ok) begin
				st = ST_BAD_HEADER;
			end else if (!rp_blks_ok) begin
				st = ST_CRC_ERROR;
			end else if (rp_npci[NPCI_DOMAIN_BIT] && rp_addr != dom_reg) begin
				st = ST_DOMAIN_MISMATCH;
			end else begin
				st = ST_OK;
			end
			v = (verdict_q.size() != 0) ? verdict_q.pop_front() : NO_VERDICT;
			if (v != NO_VERDICT) begin
				st = status_t'(v[2:0]);
			end
			r = '0;
			r.kind = ITEM_STATUS;
			r.last = 1'b1;
			r.status = st;
			r.rf_info = rp_info;
			r.addr = rp_addr;
			r.frame = rp_npci[NPCI_FRAME_LSB +: 3];
			r.group = rp_npci[NPCI_GROUP_BIT];
			r.hop = rp_npci[NPCI_HOP_LSB +: 3];
			r.dbc = rp_npci[NPCI_DOMAIN_BIT];
			r.npdu = (st == ST_OK) ? rp_pay - NPDU_W'(NPDU_BIAS) : '0;
			deframed_q.push_back(r);
			clear_packet();
		end
	endtask

	task automatic check_field(input string nm, input logic [47:0] want, input logic [47:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s expected %0h, got %0h", $time, nm, want, got);
		end
	endtask

	// Fills pkt with a packet of len bytes whose header and block CRCs are right
	// (for noise damage, random bytes only), then applies the requested damage.
	task automatic build_packet(input int len, input logic [7:0] info,
			input logic [ADDR_W-1:0] adr, input logic [7:0] npci, input damage_t dmg);
		int s;
		int n;
		int j;
		logic [15:0] c;
		pkt.delete();
		for (j = 0; j < len; j++) begin
			pkt.push_back(8'($urandom_range(0, 255)));
		end
		if (dmg != DMG_NOISE) begin
			if (len > POS_SYNC0) pkt[POS_SYNC0] = SYNC0;
			if (len > POS_SYNC1) pkt[POS_SYNC1] = SYNC1;
			if (len > POS_INFO) pkt[POS_INFO] = info;
			for (j = POS_ADDR_FIRST; j <= POS_ADDR_LAST && j < len; j++) begin
				pkt[j] = adr[8 * (POS_ADDR_LAST - j) +: 8];
			end
			if (len > POS_NPCI) pkt[POS_NPCI] = npci;
			if (len >= BLOCK1_LEN) begin
				c = crc_span(0, BLOCK1_LEN - CRC_BYTES);
				pkt[BLOCK1_LEN - 2] = c[15:8];
				pkt[BLOCK1_LEN - 1] = c[7:0];
			end
			s = BLOCK1_LEN;
			while (s < len) begin
				n = (len - s < BLOCK_LEN) ? len - s : BLOCK_LEN;
				if (n >= CRC_BYTES) begin
					c = crc_span(s, n - CRC_BYTES);
					pkt[s + n - 2] = c[15:8];
					pkt[s + n - 1] = c[7:0];
				end
				s += n;
			end
		end
		case (dmg)
			DMG_SYNC0: begin
				if (len > POS_SYNC0) pkt[POS_SYNC0] ^= 8'($urandom_range(1, 255));
			end
			DMG_SYNC1: begin
				if (len > POS_SYNC1) pkt[POS_SYNC1] ^= 8'($urandom_range(1, 255));
			end
			DMG_HDR_CRC: begin
				if (len >= BLOCK1_LEN) pkt[BLOCK1_LEN - 1] ^= 8'($urandom_range(1, 255));
			end
			DMG_BLK2: begin
				if (len > BLOCK1_LEN) pkt[BLOCK1_LEN] ^= 8'($urandom_range(1, 255));
			end
			DMG_RANDOM: begin
				j = $urandom_range(0, len - 1);
				pkt[j] ^= 8'($urandom_range(1, 255));
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_packet(input int verdict);
		rx_beat_t bt;
		verdict_q.push_back(verdict);
		for (int j = 0; j < pkt.size(); j++) begin
			bt.data = pkt[j];
			bt.eop = (j == pkt.size() - 1);
			byte_q.push_back(bt);
		end
		pkt_cnt++;
		bytes_queued += pkt.size();
	endtask

	// Mostly well-formed packets with random content; the rest are damaged,
	// short or plain noise.
	task automatic queue_random_packet();
		int kind;
		int len;
		logic [ADDR_W-1:0] adr;
		logic [7:0] npci;
		kind = $urandom_range(0, 9);
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(71, 140) : $urandom_range(21, 70);
		if (((len - BLOCK1_LEN) % BLOCK_LEN) == 1) begin
			len++;
		end
		npci = 8'($urandom_range(0, 255));
		adr = $urandom_range(0, 1) ? dom_reg : ADDR_W'({$urandom(), $urandom()});
		case (kind)
			7: build_packet(len, 8'($urandom_range(0, 255)), adr, npci, DMG_RANDOM);
			8: build_packet($urandom_range(1, MIN_PACKET - 1), 8'($urandom_range(0, 255)), adr,
				npci, DMG_NONE);
			9: build_packet($urandom_range(1, 60), 8'h00, adr, npci, DMG_NOISE);
			default: build_packet(len, 8'($urandom_range(0, 255)), adr, npci, DMG_NONE);
		endcase
		send_packet(NO_VERDICT);
	endtask

	task automatic wait_drained();
		while (byte_q.size() != 0 || rx_ch.valid === 1'b1) begin
			@(posedge clk);
		end
		while (deframed_q.size() != 0) begin
			@(posedge clk);
		end
		// A trailing byte that closes nothing may still be in flight.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_domain(input logic [ADDR_W-1:0] v);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		dom_reg = v;
	endtask

	// Rx sender: bursts of random length separated by random gaps.
	initial begin : rx_driver
		int burst_left;
		int gap_left;
		rx_beat_t bt;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		rx_ch.end_of_packet = 1'b0;
		burst_left = $urandom_range(1, 24);
		gap_left = 0;
		forever begin
			@(negedge clk);
			if (!(rx_ch.valid === 1'b1 && rx_taken !== 1'b1)) begin
				if (gap_left > 0) begin
					rx_ch.valid = 1'b0;
					gap_left--;
				end else if (byte_q.size() != 0 && arst_n) begin
					bt = byte_q.pop_front();
					rx_ch.rx_byte = bt.data;
					rx_ch.end_of_packet = bt.eop;
					rx_ch.valid = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					rx_ch.valid = 1'b0;
				end
			end
		end
	end

	// Result receiver: a repeating pattern of open, mostly open and half open
	// stretches, plus one long hold-off on request.
	initial begin : res_receiver
		logic [5:0] pat;
		res_ch.ready = 1'b0;
		pat = '0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			pat = pat + 1'b1;
			case (pat[5:4])
				2'd0: res_ch.ready = 1'b1;
				2'd3: res_ch.ready = $urandom_range(0, 1);
				default: res_ch.ready = $urandom_range(0, 3) != 0;
			endcase
		end
	end

	always @(posedge clk) begin : beat_monitor
		res_item_t want;
		if (arst_n) begin
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				if (res_ch.item_kind === ITEM_STATUS) begin
					status_out++;
					if (!$isunknown(res_ch.status)) st_seen[res_ch.status]++;
				end else begin
					payload_out++;
				end
				if (deframed_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result beat with nothing expected, expected none, got kind %0h",
						$time, res_ch.item_kind);
				end else begin
					want = deframed_q.pop_front();
					check_field("item_kind", want.kind, res_ch.item_kind);
					check_field("payload_byte", want.payload, res_ch.payload_byte);
					check_field("last_item", want.last, res_ch.last_item);
					check_field("status", want.status, res_ch.status);
					check_field("rf_info", want.rf_info, res_ch.rf_info);
					check_field("serial_or_domain", want.addr, res_ch.serial_or_domain);
					check_field("frame_number", want.frame, res_ch.frame_number);
					check_field("group_address", want.group, res_ch.group_address);
					check_field("hop_count", want.hop, res_ch.hop_count);
					check_field("domain_broadcast", want.dbc, res_ch.domain_broadcast);
					check_field("npdu_length", want.npdu, res_ch.npdu_length);
				end
			end
			if (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) begin
				bytes_in++;
				deframe_byte(rx_ch.rx_byte, rx_ch.end_of_packet);
			end
		end
		rx_taken <= arst_n && rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1;
	end

	initial begin : main_seq
		logic [ADDR_W-1:0] adr;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		hold_req = 1'b0;
		err_cnt = 0;
		pkt_cnt = 0;
		bytes_queued = 0;
		bytes_in = 0;
		payload_out = 0;
		status_out = 0;
		foreach (st_seen[i]) st_seen[i] = 0;
		dom_reg = '0;
		clear_packet();
		// len, rf-info, address, L/NPCI, address taken from domain, damage, status
		dir_rows = '{
			'{21, 8'h00, 48'h0, 8'h00, 1'b0, DMG_NONE, ST_OK},
			'{21, 8'hFF, 48'h0, 8'hFF, 1'b1, DMG_NONE, ST_OK},
			'{21, 8'h5A, 48'h0, 8'h01, 1'b0, DMG_NONE, ST_DOMAIN_MISMATCH},
			'{1, 8'h00, 48'h0, 8'h00, 1'b0, DMG_NONE, ST_SHORT},
			'{12, 8'h11, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b0, DMG_NONE, ST_SHORT},
			'{20, 8'h22, 48'h0102_0304_0506, 8'h5C, 1'b0, DMG_NONE, ST_SHORT},
			'{30, 8'h81, 48'h0123_4567_89AB, 8'h7E, 1'b0, DMG_NONE, NO_VERDICT},
			'{32, 8'h3C, 48'hA5A5_5A5A_A5A5, 8'h2A, 1'b0, DMG_NONE, NO_VERDICT},
			'{31, 8'h42, 48'h0, 8'h00, 1'b0, DMG_NONE, ST_CRC_ERROR},
			'{40, 8'h10, 48'h0, 8'h00, 1'b0, DMG_SYNC0, ST_BAD_HEADER},
			'{40, 8'h20, 48'h0, 8'h00, 1'b0, DMG_SYNC1, ST_BAD_HEADER},
			'{50, 8'h30, 48'h0, 8'h00, 1'b0, DMG_HDR_CRC, ST_CRC_ERROR},
			'{66, 8'h40, 48'h0, 8'h00, 1'b0, DMG_BLK2, ST_CRC_ERROR},
			'{513, 8'hC3, 48'h8000_0000_0001, 8'h80, 1'b0, DMG_NONE, ST_CRC_ERROR},
			'{10, 8'h60, 48'h0, 8'h00, 1'b0, DMG_SYNC0, ST_SHORT},
			'{49, 8'h70, 48'h0, 8'h00, 1'b0, DMG_SYNC1, ST_BAD_HEADER}
		};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_domain({ADDR_W{1'b1}});
		foreach (dir_rows[i]) begin
			adr = dir_rows[i].addr_is_domain ? dom_reg : dir_rows[i].addr;
			build_packet(dir_rows[i].len, dir_rows[i].info, adr, dir_rows[i].npci, dir_rows[i].dmg);
			send_packet(dir_rows[i].verdict);
		end
		wait_drained();

		// The long receiver hold-off lands on this phase, so the rx side backs up.
		write_domain('0);
		hold_req = 1'b1;
		adr = ADDR_W'(bytes_queued);
		while (bytes_queued < adr + RANDOM_BYTES) begin
			queue_random_packet();
		end
		wait_drained();

		write_domain(ADDR_W'({$urandom(), $urandom()}));
		adr = ADDR_W'(bytes_queued);
		while (bytes_queued < adr + RANDOM_BYTES) begin
			queue_random_packet();
		end
		wait_drained();

		$display("Run covered %0d packets (%0d bytes in), %0d payload beats and %0d status beats out.",
			pkt_cnt, bytes_in, payload_out, status_out);
		$display("Status beats by code: ok %0d, short %0d, header %0d, crc %0d, domain %0d.",
			st_seen[ST_OK], st_seen[ST_SHORT], st_seen[ST_BAD_HEADER], st_seen[ST_CRC_ERROR],
			st_seen[ST_DOMAIN_MISMATCH]);
		if (err_cnt == 0) begin
			$display("rf_block_crc_deframer_unit_tb passed");
		end else begin
			$display("rf_block_crc_deframer_unit_tb failed");
		end
		$finish;
	end

endmodule

/* rf_block_crc_deframer_unit.f */
hdl/rbcd_pkg.sv
hdl/rbcd_rx_if.sv
hdl/rbcd_res_if.sv
hdl/rbcd_buf.sv
hdl/rbcd_queue.sv
hdl/rbcd_front.sv
hdl/rbcd_back.sv
hdl/rf_block_crc_deframer_unit.sv
sim/rf_block_crc_deframer_unit_tb.sv
